// ===== design/lte_pkg.sv =====
// package for the latency trimmed estimate unit
// holds the window sizing constants, widths and the structs shared between modules
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package lte_pkg;

  // window and field sizing
  localparam int WinDepth = 16;
  localparam int SampleW  = 16;
  localparam int SlotW    = $clog2(WinDepth);
  localparam int CntW     = $clog2(WinDepth + 1);
  localparam int HeldW    = 5;
  localparam int EstW     = 17;
  localparam int TrimMax  = 4;

  // arithmetic widths
  localparam int SumW     = SampleW + CntW;
  localparam int SqW      = 2 * SampleW + CntW;
  localparam int DivW     = SqW + 2;
  localparam int RootW    = (DivW + 1) / 2;
  localparam int RemW     = RootW + 2;
  localparam int DivCntW  = $clog2(DivW + 1);
  localparam int RootCntW = $clog2(RootW + 1);

  localparam logic [EstW-1:0] EstMax = '1;

  // one classified sample handed from the front to the back
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [SlotW-1:0]   slot;
    logic [CntW-1:0]    held;
    logic [CntW-1:0]    keep;
    logic [CntW-1:0]    first;
  } job_t;

  // one finished result
  typedef struct packed {
    logic [EstW-1:0]  estimate;
    logic [HeldW-1:0] held;
  } result_t;

  // shared divider
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

  // square root unit
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

// ===== design/lte_front.sv =====
// front end of the latency trimmed estimate unit
// accepts samples, keeps the window bookkeeping and queues classified jobs
// depends on lte_pkg
`timescale 1ns / 1ps
`default_nettype none

module lte_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [15:0]   latency_sample_i,
  output lte_pkg::job_t      job_o,
  output logic               job_valid_o,
  input  wire logic          job_ready_i
);

  logic [lte_pkg::CntW-1:0]  held_q, held_d;
  logic [lte_pkg::SlotW-1:0] oldest_q, oldest_d;
  logic [lte_pkg::CntW-1:0]  removed;
  lte_pkg::job_t             new_job;
  lte_pkg::job_t             q_mem [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                fill_q, fill_d;
  logic                      accept, take;

  assign full_o      = (fill_q == 2'd2);
  assign job_valid_o = (fill_q != 2'd0);
  assign job_o       = q_mem[rd_ptr_q];
  assign accept      = push_i & ~full_o;
  assign take        = job_valid_o & job_ready_i;

  // window bookkeeping and trim classification
  always_comb begin
    held_d   = held_q;
    oldest_d = oldest_q;
    new_job.sample = latency_sample_i;
    if (held_q < lte_pkg::CntW'(lte_pkg::WinDepth)) begin
      // oldest slot stays at zero while the window fills
      new_job.slot = lte_pkg::SlotW'(held_q);
      held_d       = held_q + 1'b1;
    end else begin
      new_job.slot = oldest_q;
      if (oldest_q == lte_pkg::SlotW'(lte_pkg::WinDepth - 1)) begin
        oldest_d = '0;
      end else begin
        oldest_d = oldest_q + 1'b1;
      end
    end
    new_job.held = held_d;
    if (held_d > lte_pkg::CntW'(lte_pkg::TrimMax + 2)) begin
      removed = lte_pkg::CntW'(lte_pkg::TrimMax);
    end else if (held_d >= lte_pkg::CntW'(2)) begin
      removed = held_d - lte_pkg::CntW'(2);
    end else begin
      removed = '0;
    end
    new_job.keep  = held_d - removed;
    new_job.first = (removed + 1'b1) >> 1;
  end

  // queue fill level
  always_comb begin
    fill_d = fill_q;
    if (accept && !take) begin
      fill_d = fill_q + 2'd1;
    end else if (take && !accept) begin
      fill_d = fill_q - 2'd1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      oldest_q <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (accept) begin
        held_q   <= held_d;
        oldest_q <= oldest_d;
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (take) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= new_job;
    end
  end

endmodule

`default_nettype wire

// ===== design/lte_div.sv =====
// shared restoring divider, one quotient bit per cycle
// divides a wide dividend by the small kept-sample count
// depends on lte_pkg
`timescale 1ns / 1ps
`default_nettype none

module lte_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lte_pkg::div_req_t req_i,
  output lte_pkg::div_rsp_t      rsp_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [lte_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [lte_pkg::DivW-1:0]    quo_q, quo_d;
  logic [lte_pkg::CntW-1:0]    rem_q, rem_d;
  logic [lte_pkg::CntW-1:0]    dsr_q, dsr_d;
  logic [lte_pkg::CntW:0]      rem_sh;

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // one shift-subtract step a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q, quo_q[lte_pkg::DivW-1]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      cnt_d  = lte_pkg::DivCntW'(lte_pkg::DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[lte_pkg::DivW-2:0], 1'b0};
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d    = lte_pkg::CntW'(rem_sh - {1'b0, dsr_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = rem_sh[lte_pkg::CntW-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == lte_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

endmodule

`default_nettype wire

// ===== design/lte_sqrt.sv =====
// integer square root, one root bit per cycle (digit by digit)
// gives floor(sqrt(radicand))
// depends on lte_pkg
`timescale 1ns / 1ps
`default_nettype none

module lte_sqrt (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lte_pkg::sqrt_req_t req_i,
  output lte_pkg::sqrt_rsp_t      rsp_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [lte_pkg::RootCntW-1:0] cnt_q, cnt_d;
  logic [2*lte_pkg::RootW-1:0]  op_q, op_d;
  logic [lte_pkg::RemW-1:0]     rem_q, rem_d;
  logic [lte_pkg::RootW-1:0]    root_q, root_d;
  logic [lte_pkg::RemW+1:0]     rem_sh;
  logic [lte_pkg::RemW+1:0]     trial;

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_sh = {rem_q, op_q[2*lte_pkg::RootW-1 -: 2]};
    trial  = (lte_pkg::RemW + 2)'({root_q, 2'b01});
    if (req_i.start) begin
      op_d   = (2 * lte_pkg::RootW)'(req_i.radicand);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = lte_pkg::RootCntW'(lte_pkg::RootW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      op_d = {op_q[2*lte_pkg::RootW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = lte_pkg::RemW'(rem_sh - trial);
        root_d = {root_q[lte_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_d  = lte_pkg::RemW'(rem_sh);
        root_d = {root_q[lte_pkg::RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == lte_pkg::RootCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

`default_nettype wire

// ===== design/lte_back.sv =====
// back end of the latency trimmed estimate unit
// holds the sample window, sorts it in a row of compare-swap cells, forms the
// trimmed mean and spread with the shared divider and root unit, queues results
// depends on lte_pkg, lte_div and lte_sqrt
`timescale 1ns / 1ps
`default_nettype none

module lte_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lte_pkg::job_t job_i,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [16:0]        estimate_o,
  output logic [4:0]         samples_held_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_SORT = 8'b0000_0010,
    S_SUM  = 8'b0000_0100,
    S_MEAN = 8'b0000_1000,
    S_SQ   = 8'b0001_0000,
    S_VAR  = 8'b0010_0000,
    S_ROOT = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } back_state_e;

  back_state_e                   state_q, state_d;
  logic [lte_pkg::SampleW-1:0]   win_q [lte_pkg::WinDepth];
  logic [lte_pkg::SampleW-1:0]   srt_q [lte_pkg::WinDepth];
  logic [lte_pkg::SampleW-1:0]   srt_d [lte_pkg::WinDepth];
  logic [lte_pkg::SampleW-1:0]   sort_nxt [lte_pkg::WinDepth];
  logic [lte_pkg::SampleW-1:0]   rot [lte_pkg::WinDepth];
  logic [lte_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [lte_pkg::CntW-1:0]      held_q, held_d;
  logic [lte_pkg::CntW-1:0]      keep_q, keep_d;
  logic [lte_pkg::CntW-1:0]      first_q, first_d;
  logic [lte_pkg::SumW-1:0]      sum_q, sum_d;
  logic [lte_pkg::SampleW-1:0]   mean_q, mean_d;
  logic [2*lte_pkg::SampleW-1:0] prod_q, prod_d;
  logic                          prod_vld_q, prod_vld_d;
  logic [lte_pkg::SqW-1:0]       sq_q, sq_d;
  logic [lte_pkg::EstW-1:0]      est_q, est_d;
  logic [lte_pkg::SampleW-1:0]   dev;
  logic [lte_pkg::RootW:0]       est_sum;
  logic                          in_range;
  logic                          win_we;
  logic                          res_push;

  lte_pkg::div_req_t             div_req;
  lte_pkg::div_rsp_t             div_rsp;
  lte_pkg::sqrt_req_t            sqrt_req;
  lte_pkg::sqrt_rsp_t            sqrt_rsp;

  lte_pkg::result_t              res_mem [2];
  lte_pkg::result_t              res_in;
  logic                          res_wr_q, res_rd_q;
  logic [1:0]                    res_fill_q, res_fill_d;
  logic                          res_full, res_take;

  lte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lte_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // position counter inside the kept band of the sorted row
  assign in_range = ({1'b0, cnt_q} >= {1'b0, first_q}) &&
                    ({1'b0, cnt_q} < ({1'b0, first_q} + {1'b0, keep_q}));

  // odd-even transposition cells, descending, and the row rotation
  always_comb begin
    for (int i = 0; i < lte_pkg::WinDepth; i++) begin
      sort_nxt[i] = srt_q[i];
      rot[i]      = srt_q[(i + 1) % lte_pkg::WinDepth];
    end
    for (int i = 0; i < lte_pkg::WinDepth - 1; i++) begin
      if (((i % 2) == 1) == cnt_q[0]) begin
        if (srt_q[i] < srt_q[i + 1]) begin
          sort_nxt[i]     = srt_q[i + 1];
          sort_nxt[i + 1] = srt_q[i];
        end
      end
    end
  end

  // absolute deviation from the mean of the head of the row
  assign dev = (srt_q[0] >= mean_q) ? (srt_q[0] - mean_q) : (mean_q - srt_q[0]);

  // mean plus root term, widened before the saturation check
  assign est_sum = (lte_pkg::RootW + 1)'(mean_q) + (lte_pkg::RootW + 1)'(sqrt_rsp.root);

  // sequencer
  always_comb begin
    state_d    = state_q;
    srt_d      = srt_q;
    cnt_d      = cnt_q;
    held_d     = held_q;
    keep_d     = keep_q;
    first_d    = first_q;
    sum_d      = sum_q;
    mean_d     = mean_q;
    prod_d     = prod_q;
    prod_vld_d = 1'b0;
    sq_d       = sq_q;
    est_d      = est_q;
    job_ready_o = 1'b0;
    win_we     = 1'b0;
    res_push   = 1'b0;
    div_req    = '0;
    sqrt_req   = '0;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_ready_o = 1'b1;
          win_we      = 1'b1;
          held_d      = job_i.held;
          keep_d      = job_i.keep;
          first_d     = job_i.first;
          // load valid entries, pad with zero so they sink below the held ones
          for (int i = 0; i < lte_pkg::WinDepth; i++) begin
            if (lte_pkg::CntW'(i) < job_i.held) begin
              srt_d[i] = (lte_pkg::SlotW'(i) == job_i.slot) ? job_i.sample : win_q[i];
            end else begin
              srt_d[i] = '0;
            end
          end
          if (job_i.held == lte_pkg::CntW'(1)) begin
            // a lone sample is its own estimate
            est_d   = lte_pkg::EstW'(job_i.sample);
            state_d = S_DONE;
          end else begin
            cnt_d   = '0;
            state_d = S_SORT;
          end
        end
      end

      S_SORT: begin
        srt_d = sort_nxt;
        if (cnt_q == lte_pkg::CntW'(lte_pkg::WinDepth - 1)) begin
          cnt_d   = '0;
          sum_d   = '0;
          state_d = S_SUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_SUM: begin
        srt_d = rot;
        if (in_range) begin
          sum_d = sum_q + lte_pkg::SumW'(srt_q[0]);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == lte_pkg::CntW'(lte_pkg::WinDepth - 1)) begin
          div_req.start    = 1'b1;
          div_req.dividend = lte_pkg::DivW'(sum_d);
          div_req.divisor  = keep_q;
          state_d          = S_MEAN;
        end
      end

      S_MEAN: begin
        if (div_rsp.done) begin
          mean_d  = div_rsp.quotient[lte_pkg::SampleW-1:0];
          cnt_d   = '0;
          sq_d    = '0;
          state_d = S_SQ;
        end
      end

      S_SQ: begin
        // square stage is registered, accumulate stage works in the cycle after it
        if (prod_vld_q) begin
          sq_d = sq_q + lte_pkg::SqW'(prod_q);
        end
        if (cnt_q == lte_pkg::CntW'(lte_pkg::WinDepth)) begin
          div_req.start    = 1'b1;
          div_req.dividend = {sq_d, 2'b00};
          div_req.divisor  = keep_q;
          state_d          = S_VAR;
        end else begin
          prod_d     = dev * dev;
          prod_vld_d = in_range;
          srt_d      = rot;
          cnt_d      = cnt_q + 1'b1;
        end
      end

      S_VAR: begin
        if (div_rsp.done) begin
          sqrt_req.start    = 1'b1;
          sqrt_req.radicand = div_rsp.quotient;
          state_d           = S_ROOT;
        end
      end

      S_ROOT: begin
        if (sqrt_rsp.done) begin
          if (est_sum > (lte_pkg::RootW + 1)'(lte_pkg::EstMax)) begin
            est_d = lte_pkg::EstMax;
          end else begin
            est_d = lte_pkg::EstW'(est_sum);
          end
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!res_full) begin
          res_push = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result queue
  assign res_full       = (res_fill_q == 2'd2);
  assign empty_o        = (res_fill_q == 2'd0);
  assign res_take       = pop_i & ~empty_o;
  assign res_in.estimate = est_q;
  assign res_in.held     = lte_pkg::HeldW'(held_q);
  assign estimate_o     = res_mem[res_rd_q].estimate;
  assign samples_held_o = res_mem[res_rd_q].held;

  always_comb begin
    res_fill_d = res_fill_q;
    if (res_push && !res_take) begin
      res_fill_d = res_fill_q + 2'd1;
    end else if (res_take && !res_push) begin
      res_fill_d = res_fill_q - 2'd1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      prod_vld_q <= 1'b0;
      res_wr_q   <= 1'b0;
      res_rd_q   <= 1'b0;
      res_fill_q <= 2'd0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      prod_vld_q <= prod_vld_d;
      res_fill_q <= res_fill_d;
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_take) begin
        res_rd_q <= ~res_rd_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    srt_q   <= srt_d;
    held_q  <= held_d;
    keep_q  <= keep_d;
    first_q <= first_d;
    sum_q   <= sum_d;
    mean_q  <= mean_d;
    prod_q  <= prod_d;
    sq_q    <= sq_d;
    est_q   <= est_d;
    if (win_we) begin
      win_q[job_i.slot] <= job_i.sample;
    end
    if (res_push) begin
      res_mem[res_wr_q] <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/latency_trimmed_estimate_unit.sv =====
// Latency trimmed estimate unit: takes one 16-bit round-trip sample per beat,
// keeps the last 16 in a window and returns one beat per sample carrying
// the trimmed mean plus two standard deviations (saturating at 17 bits) and the
// number of samples held. The front queue takes up to two samples while the
// back end is busy, and two finished results wait on the output side. The
// first sample after reset skips the sort and the arithmetic and goes straight
// from the job take to the result queue; every later one passes through the back
// end in order: the job is taken, sorted in the compare-swap row, the kept band
// is summed, the one-bit-per-cycle divider forms the mean, the squared
// deviations are summed, the same divider forms the variance, the square root
// unit forms the root term and the result is queued. The shared divider takes
// most of the time in the back end. No clearing pass follows reset.
// depends on lte_pkg, lte_front and lte_back
`timescale 1ns / 1ps
`default_nettype none

module latency_trimmed_estimate_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] latency_sample_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [16:0]      estimate_o,
  output logic [4:0]       samples_held_o
);

  lte_pkg::job_t job;
  logic          job_valid;
  logic          job_ready;

  // accept and classify samples
  lte_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .latency_sample_i (latency_sample_i),
    .job_o            (job),
    .job_valid_o      (job_valid),
    .job_ready_i      (job_ready)
  );

  // window, sort and estimate
  lte_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job),
    .job_valid_i    (job_valid),
    .job_ready_o    (job_ready),
    .empty_o        (empty),
    .pop_i          (pop),
    .estimate_o     (estimate_o),
    .samples_held_o (samples_held_o)
  );

endmodule

`default_nettype wire

// ===== design/lte_checker.sv =====
// port-level checker for the latency trimmed estimate unit
// bound to the top level; depends on lte_pkg
`timescale 1ns / 1ps
`default_nettype none

module lte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [16:0] estimate_o,
  input wire logic [4:0]  samples_held_o
);

  logic       in_beat, out_beat;
  logic [3:0] pending_q;
  logic       last_vld_q;
  logic [4:0] last_held_q;

  assign in_beat  = push & ~full;
  assign out_beat = pop & ~empty;

  // samples taken but not yet returned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      last_vld_q  <= 1'b0;
      last_held_q <= '0;
    end else begin
      pending_q <= pending_q + {3'd0, in_beat} - {3'd0, out_beat};
      if (out_beat) begin
        last_vld_q  <= 1'b1;
        last_held_q <= samples_held_o;
      end
    end
  end

  // no result without an outstanding sample
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != 4'd0)
    else $error("result shown with no sample outstanding");

  // a result that waits keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(estimate_o) && $stable(samples_held_o)))
    else $error("waiting result changed");

  // held count grows by one per beat until the window is full
  a_held_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_vld_q) |->
      (samples_held_o == last_held_q + 5'd1) ||
      ((last_held_q == 5'(lte_pkg::WinDepth)) && (samples_held_o == 5'(lte_pkg::WinDepth))))
    else $error("held count out of sequence");

  // first result after reset carries a single sample
  a_held_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_vld_q) |-> samples_held_o == 5'd1)
    else $error("first result does not hold one sample");

endmodule

bind latency_trimmed_estimate_unit lte_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .estimate_o     (estimate_o),
  .samples_held_o (samples_held_o)
);

`default_nettype wire

// ===== dv/latency_trimmed_estimate_unit_test.sv =====
// self-checking bench for latency_trimmed_estimate_unit: directed table then random latency beats
// each accepted sample is run through a local window predictor and every result beat is compared
// depends on lte_pkg and latency_trimmed_estimate_unit
`timescale 1ns / 1ps

module latency_trimmed_estimate_unit_test;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int          RandomBeats = 900;
  localparam int          CalmTail    = 100;
  localparam int          DrainCycles = 200;
  localparam int          ShownFaults = 10;

  // kinds of random latency traffic
  typedef enum logic [1:0] {
    MixWide,
    MixClustered,
    MixExtremes,
    MixTiny
  } latency_mix_e;

  typedef struct {
    logic [lte_pkg::SampleW-1:0] sample;
    bit                          pinned;
    lte_pkg::result_t            outcome;
  } directed_row_t;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              push             = 1'b0;
  logic [15:0]       latency_sample_i = '0;
  logic              pop              = 1'b0;
  logic              full;
  logic              empty;
  logic [16:0]       estimate_o;
  logic [4:0]        samples_held_o;

  logic [lte_pkg::SampleW-1:0] recent_latencies[$];
  lte_pkg::result_t            pending_estimates[$];
  directed_row_t               directed_rows[24];
  int unsigned                 fault_count   = 0;
  int unsigned                 cycle_count   = 0;
  int                          push_idle_pct = 20;
  int                          pop_idle_pct  = 20;
  int                          pop_hold      = 0;
  bit                          quiet_tail    = 1'b0;

  latency_trimmed_estimate_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .latency_sample_i(latency_sample_i),
    .empty           (empty),
    .pop             (pop),
    .estimate_o      (estimate_o),
    .samples_held_o  (samples_held_o)
  );

  always #1 clk_i = ~clk_i;

  // floor of the square root, one result bit per pass
  function automatic longint unsigned root_floor(input longint unsigned radicand);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > radicand) probe = probe >> 2;
    while (probe != 0) begin
      if (radicand >= root + probe) begin
        radicand = radicand - (root + probe);
        root     = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // trimmed mean plus two sigma over the samples now in the window
  function automatic logic [lte_pkg::EstW-1:0] pessimistic_latency();
    logic [lte_pkg::SampleW-1:0] ranked[lte_pkg::WinDepth];
    logic [lte_pkg::SampleW-1:0] pick;
    int                          n, i, j, drop, keep, first;
    longint unsigned             total, mean, spread, dev, est;
    n = recent_latencies.size();
    if (n == 1) return lte_pkg::EstW'(recent_latencies[0]);
    for (i = 0; i < n; i++) ranked[i] = recent_latencies[i];
    // insertion sort, largest first
    for (i = 1; i < n; i++) begin
      pick = ranked[i];
      j    = i;
      while (j > 0 && ranked[j-1] < pick) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = pick;
    end
    // alternate trims from the top and bottom, never below two kept
    drop  = (n - 2 > lte_pkg::TrimMax) ? lte_pkg::TrimMax : n - 2;
    keep  = n - drop;
    first = (drop + 1) / 2;
    total = 0;
    for (i = 0; i < keep; i++) total += ranked[first + i];
    mean   = total / keep;
    spread = 0;
    for (i = 0; i < keep; i++) begin
      dev    = (ranked[first + i] >= mean) ? ranked[first + i] - mean : mean - ranked[first + i];
      spread += dev * dev;
    end
    est = mean + root_floor((4 * spread) / keep);
    if (est > lte_pkg::EstMax) return lte_pkg::EstMax;
    return lte_pkg::EstW'(est);
  endfunction

  function automatic logic [lte_pkg::SampleW-1:0] next_latency(
      input latency_mix_e mix, input logic [lte_pkg::SampleW-1:0] base);
    logic [lte_pkg::SampleW:0] sum;
    case (mix)
      MixWide: begin
        return lte_pkg::SampleW'($urandom_range(0, 65535));
      end
      MixClustered: begin
        // steady link with jitter and the odd spike
        if ($urandom_range(0, 15) == 0) return lte_pkg::SampleW'($urandom_range(0, 65535));
        sum = {1'b0, base} + (lte_pkg::SampleW + 1)'($urandom_range(0, 255));
        return sum[lte_pkg::SampleW] ? '1 : sum[lte_pkg::SampleW-1:0];
      end
      MixExtremes: begin
        case ($urandom_range(0, 5))
          0: return '0;
          1: return '1;
          2: return lte_pkg::SampleW'(1);
          3: return lte_pkg::SampleW'(16'hFFFE);
          4: return lte_pkg::SampleW'(16'h8000);
          default: return lte_pkg::SampleW'(16'h7FFF);
        endcase
      end
      default: begin
        return lte_pkg::SampleW'($urandom_range(0, 31));
      end
    endcase
  endfunction

  function automatic int idle_level();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  task automatic note_fault(input string line);
    fault_count++;
    if (fault_count <= ShownFaults) $display("%s", line);
  endtask

  // offer one sample beat and record the estimate it should produce
  task automatic send_latency(input logic [lte_pkg::SampleW-1:0] sample, input bit pinned,
                              input lte_pkg::result_t pinned_beat);
    lte_pkg::result_t predicted;
    if (!quiet_tail && $urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    push             <= 1'b1;
    latency_sample_i <= sample;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    recent_latencies = {recent_latencies, sample};
    if (recent_latencies.size() > lte_pkg::WinDepth) void'(recent_latencies.pop_front());
    predicted.estimate = pessimistic_latency();
    predicted.held     = lte_pkg::HeldW'(recent_latencies.size());
    if (pinned) predicted = pinned_beat;
    pending_estimates = {pending_estimates, predicted};
  endtask

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
    end else if (!quiet_tail && $urandom_range(0, 99) < pop_idle_pct) begin
      pop      <= 1'b0;
      pop_hold <= $urandom_range(0, 14);
    end else begin
      pop <= 1'b1;
    end
  end

  // compare each result beat against the oldest pending estimate
  always @(posedge clk_i) begin : check_results
    lte_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_estimates.size() == 0) begin
        note_fault($sformatf("unexpected result beat: estimate %0d held %0d",
                             estimate_o, samples_held_o));
      end else begin
        want = pending_estimates.pop_front();
        if (estimate_o !== want.estimate || samples_held_o !== want.held)
          note_fault($sformatf("result mismatch: estimate exp %0d got %0d, held exp %0d got %0d",
                               want.estimate, estimate_o, want.held, samples_held_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    latency_mix_e                mix;
    logic [lte_pkg::SampleW-1:0] base;
    int                          row, beat;
    // first beat after reset is the sample itself, the rest fill and wrap the window
    directed_rows = '{
      '{16'hFFFF, 1'b1, '{17'd65535, 5'd1}},
      '{16'h0000, 1'b0, '{'0, '0}},
      '{16'hFFFF, 1'b0, '{'0, '0}},
      '{16'h0000, 1'b0, '{'0, '0}},
      '{16'hFFFF, 1'b0, '{'0, '0}},
      '{16'h0000, 1'b0, '{'0, '0}},
      '{16'h0001, 1'b0, '{'0, '0}},
      '{16'h8000, 1'b0, '{'0, '0}},
      '{16'h7FFF, 1'b0, '{'0, '0}},
      '{16'hAAAA, 1'b0, '{'0, '0}},
      '{16'h5555, 1'b0, '{'0, '0}},
      '{16'hFFFE, 1'b0, '{'0, '0}},
      '{16'h0000, 1'b0, '{'0, '0}},
      '{16'h0000, 1'b0, '{'0, '0}},
      '{16'hFFFF, 1'b0, '{'0, '0}},
      '{16'hFFFF, 1'b0, '{'0, '0}},
      '{16'hFFFF, 1'b0, '{'0, '0}},
      '{16'hFFFF, 1'b0, '{'0, '0}},
      '{16'h1234, 1'b0, '{'0, '0}},
      '{16'h0002, 1'b0, '{'0, '0}},
      '{16'hFFFF, 1'b0, '{'0, '0}},
      '{16'h0100, 1'b0, '{'0, '0}},
      '{16'h8001, 1'b0, '{'0, '0}},
      '{16'h7FFE, 1'b0, '{'0, '0}}
    };
    mix  = MixWide;
    base = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < $size(directed_rows); row++)
      send_latency(directed_rows[row].sample, directed_rows[row].pinned,
                   directed_rows[row].outcome);

    // random traffic in segments of one flavour and one idling level
    for (beat = 0; beat < RandomBeats; beat++) begin
      if (beat % 50 == 0) begin
        mix           = latency_mix_e'($urandom_range(0, 3));
        base          = lte_pkg::SampleW'($urandom_range(0, 65535));
        push_idle_pct = idle_level();
        pop_idle_pct  = idle_level();
      end
      if (beat == RandomBeats - CalmTail) quiet_tail = 1'b1;
      send_latency(next_latency(mix, base), 1'b0, '0);
    end
    push <= 1'b0;

    // drain, then allow time for any stray beat
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
